FILE: design/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared widths, register indexes and limits of the spring gradient core.
// ----------------------------------------------------------------------------
package spg_pkg;

  // Coordinates and configuration
  localparam int COORD_W = 32;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_REST_LENGTH = 1'd0;
  localparam logic [IDX_W-1:0] REG_STIFFNESS   = 1'd1;

  // Difference magnitude, squares, square root
  localparam int MAG_W  = COORD_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int SUM_W  = SQ_W;
  localparam int ROOT_W = 34;

  // Numerator, after the Q16 shift, and quotient
  localparam int KMAG_W = CFG_W + MAG_W;
  localparam int PLO_W  = MAG_W + ROOT_W;
  localparam int PHI_W  = (KMAG_W - MAG_W) + ROOT_W;
  localparam int PROD_W = KMAG_W + ROOT_W;
  localparam int FRAC_W = 16;
  localparam int NUM_W  = PROD_W - FRAC_W;
  localparam int Q_W    = 47;

  // Result
  localparam int GRAD_W = Q_W + 1;
  localparam logic [GRAD_W-1:0] MAXMAG = {1'b0, {Q_W{1'b1}}};

endpackage

FILE: design/spring_energy_gradient_core.sv
// ----------------------------------------------------------------------------
// spring_energy_gradient_core
// Hookean spring energy gradient for a pair of particles in 3-D.
// ----------------------------------------------------------------------------
// Fully pipelined: one spring request is accepted every clock unless the output
// stalls; its result passes 3 front stages, 34 square-root stages, 3 multiply
// stages, 48 divider stages and the output register. Latency is set by the bit-per-
// stage square root and divider. The whole pipe advances together and holds
// while a result waits at the output with out_tready low. Coincident particles
// give zero gradients with degenerate set; clamped components set saturated.
// Configuration may only be written while the pipe is empty.
module spring_energy_gradient_core (
  input  logic                      clk,
  input  logic                      rst_n,
  // first_x, first_y, first_z, second_x, second_y, second_z (32 b each)
  input  logic [191:0]              in_tdata,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // grad_first_x/y/z, grad_second_x/y/z (48 b each)
  output logic [287:0]              out_tdata,
  // degenerate, saturated
  output logic [1:0]                out_tuser,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  logic                      cfg_we,
  input  logic [spg_pkg::IDX_W-1:0] cfg_index,
  input  logic [spg_pkg::CFG_W-1:0] cfg_wdata
);
  import spg_pkg::*;

  localparam int SQ_TAG_W  = 3 + 3 * MAG_W;
  localparam int DIV_TAG_W = 5;

  logic             en;
  logic [CFG_W-1:0] rest_r;
  logic [CFG_W-1:0] stiff_r;

  // Pipe advances unless a result is stuck at the output
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r  <= CFG_W'(65536);
      stiff_r <= CFG_W'(65536);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_REST_LENGTH: rest_r  <= cfg_wdata;
        REG_STIFFNESS:   stiff_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  // S1: coordinate differences as sign and magnitude
  logic             v1_r;
  logic [MAG_W-1:0] mag1_r [3];
  logic [2:0]       neg1_r;
  logic [MAG_W-1:0] d    [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      d[l] = {in_tdata[COORD_W*l + COORD_W-1], in_tdata[COORD_W*l +: COORD_W]}
           - {in_tdata[COORD_W*(l+3) + COORD_W-1], in_tdata[COORD_W*(l+3) +: COORD_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        neg1_r[l] <= d[l][MAG_W-1];
        mag1_r[l] <= d[l][MAG_W-1] ? (~d[l] + MAG_W'(1)) : d[l];
      end
    end
  end

  // S2: squares
  logic             v2_r;
  logic [SQ_W-1:0]  sq2_r  [3];
  logic [MAG_W-1:0] mag2_r [3];
  logic [2:0]       neg2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg2_r <= neg1_r;
      for (int l = 0; l < 3; l++) begin
        sq2_r[l]  <= mag1_r[l] * mag1_r[l];
        mag2_r[l] <= mag1_r[l];
      end
    end
  end

  // S3: sum of squares (below 3 * 2^64)
  logic             v3_r;
  logic [SUM_W-1:0] sum3_r;
  logic [SQ_TAG_W-1:0] tag3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3_r <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      tag3_r <= {neg2_r, mag2_r[2], mag2_r[1], mag2_r[0]};
    end
  end

  // Square root
  logic                sq_v;
  logic [ROOT_W-1:0]   sq_len;
  logic [SQ_TAG_W-1:0] sq_tag;

  spg_isqrt #(.TAG_W(SQ_TAG_W)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_n      (sum3_r),
    .in_tag    (tag3_r),
    .out_valid (sq_v),
    .out_root  (sq_len),
    .out_tag   (sq_tag)
  );

  // S4: length offset and stiffness times magnitude
  logic              v4_r;
  logic              deg4_r;
  logic              lneg4_r;
  logic [2:0]        neg4_r;
  logic [ROOT_W-1:0] len4_r;
  logic [ROOT_W-1:0] ldiff4_r;
  logic [KMAG_W-1:0] kmag4_r [3];
  logic [ROOT_W-1:0] rest_ext;
  logic              lneg;

  assign rest_ext = {{(ROOT_W-CFG_W){1'b0}}, rest_r};
  assign lneg     = sq_len < rest_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= sq_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg4_r   <= sq_len == '0;
      lneg4_r  <= lneg;
      neg4_r   <= sq_tag[SQ_TAG_W-1 -: 3];
      len4_r   <= sq_len;
      ldiff4_r <= lneg ? (rest_ext - sq_len) : (sq_len - rest_ext);
      for (int l = 0; l < 3; l++) begin
        kmag4_r[l] <= stiff_r * sq_tag[MAG_W*l +: MAG_W];
      end
    end
  end

  // S5: partial products against the length offset
  logic              v5_r;
  logic              deg5_r;
  logic              lneg5_r;
  logic [2:0]        neg5_r;
  logic [ROOT_W-1:0] len5_r;
  logic [PLO_W-1:0]  plo5_r [3];
  logic [PHI_W-1:0]  phi5_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg5_r  <= deg4_r;
      lneg5_r <= lneg4_r;
      neg5_r  <= neg4_r;
      len5_r  <= len4_r;
      for (int l = 0; l < 3; l++) begin
        plo5_r[l] <= kmag4_r[l][MAG_W-1:0] * ldiff4_r;
        phi5_r[l] <= kmag4_r[l][KMAG_W-1:MAG_W] * ldiff4_r;
      end
    end
  end

  // S6: full numerator, Q16 fraction dropped
  logic                 v6_r;
  logic [DIV_TAG_W-1:0] tag6_r;
  logic [ROOT_W-1:0]    len6_r;
  logic [NUM_W-1:0]     num6_r [3];
  logic [PROD_W-1:0]    prod   [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      prod[l] = {phi5_r[l], {MAG_W{1'b0}}} + {{(PROD_W-PLO_W){1'b0}}, plo5_r[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag6_r <= {deg5_r, lneg5_r, neg5_r};
      len6_r <= len5_r;
      for (int l = 0; l < 3; l++) num6_r[l] <= prod[l][PROD_W-1:FRAC_W];
    end
  end

  // Divide by length
  logic                 dv_v;
  logic [Q_W-1:0]       dv_q [3];
  logic [2:0]           dv_ovf;
  logic [DIV_TAG_W-1:0] dv_tag;

  spg_div #(.TAG_W(DIV_TAG_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v6_r),
    .in_len    (len6_r),
    .in_num    (num6_r),
    .in_tag    (tag6_r),
    .out_valid (dv_v),
    .out_q     (dv_q),
    .out_ovf   (dv_ovf),
    .out_tag   (dv_tag)
  );

  // Output register: clamp, sign, negate for the second particle
  logic              deg;
  logic [GRAD_W-1:0] qmag  [3];
  logic [GRAD_W-1:0] first [3];

  assign deg = dv_tag[4];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      qmag[l]  = dv_ovf[l] ? MAXMAG : {1'b0, dv_q[l]};
      first[l] = (dv_tag[l] != dv_tag[3]) ? (~qmag[l] + GRAD_W'(1)) : qmag[l];
      if (deg) first[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (en) out_tvalid <= dv_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        out_tdata[GRAD_W*l +: GRAD_W]     <= first[l];
        out_tdata[GRAD_W*(l+3) +: GRAD_W] <= ~first[l] + GRAD_W'(1);
      end
      out_tuser <= {(|dv_ovf) && !deg, deg};
    end
  end

endmodule

FILE: design/spg_isqrt.sv
// ----------------------------------------------------------------------------
// spg_isqrt
// Pipelined floor square root: one result bit per register stage.
// ----------------------------------------------------------------------------
module spg_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spg_pkg::SUM_W-1:0]  in_n,
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [spg_pkg::ROOT_W-1:0] out_root,
  output logic [TAG_W-1:0]           out_tag
);
  import spg_pkg::*;

  localparam int NS = ROOT_W;

  logic              v_r    [NS];
  logic [SUM_W-1:0]  rem_r  [NS];
  logic [ROOT_W-1:0] root_r [NS];
  logic [TAG_W-1:0]  tag_r  [NS];

  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam int B = NS - 1 - i;
    logic              pv;
    logic [SUM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [TAG_W-1:0]  ptag;
    logic [SUM_W+1:0]  inc;
    logic              take;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = in_n;
      assign proot = '0;
      assign ptag  = in_tag;
    end else begin : g_next
      assign pv    = v_r[i-1];
      assign prem  = rem_r[i-1];
      assign proot = root_r[i-1];
      assign ptag  = tag_r[i-1];
    end

    // trial: (2r + 2^B) * 2^B against the residue
    always_comb begin
      inc  = ({{(SUM_W+2-ROOT_W){1'b0}}, proot} << (B + 1))
           | ({{(SUM_W+1){1'b0}}, 1'b1} << (2 * B));
      take = {2'b00, prem} >= inc;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= take ? (prem - inc[SUM_W-1:0]) : prem;
        root_r[i] <= take ? (proot | (ROOT_W'(1) << B)) : proot;
        tag_r[i]  <= ptag;
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_tag   = tag_r[NS-1];

endmodule

FILE: design/spg_div.sv
// ----------------------------------------------------------------------------
// spg_div
// Three-lane pipelined restoring divider with a common divisor; one quotient
// bit per stage, overflow past the 47-bit quotient flagged up front.
// ----------------------------------------------------------------------------
module spg_div #(
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [spg_pkg::ROOT_W-1:0] in_len,
  input  logic [spg_pkg::NUM_W-1:0]  in_num [3],
  input  logic [TAG_W-1:0]           in_tag,
  output logic                       out_valid,
  output logic [spg_pkg::Q_W-1:0]    out_q   [3],
  output logic [2:0]                 out_ovf,
  output logic [TAG_W-1:0]           out_tag
);
  import spg_pkg::*;

  localparam int NS   = Q_W + 1;
  localparam int HI_W = NUM_W - Q_W;

  logic              v_r   [NS];
  logic [ROOT_W-1:0] len_r [NS];
  logic [TAG_W-1:0]  tag_r [NS];
  logic [2:0]        ovf_r [NS];
  logic [ROOT_W-1:0] rem_r [NS][3];
  logic [Q_W-1:0]    low_r [NS][3];

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) v_r[s] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < NS; s++) v_r[s] <= v_r[s-1];
    end
  end

  // Setup stage: high part against divisor decides overflow
  always_ff @(posedge clk) begin
    if (en) begin
      len_r[0] <= in_len;
      tag_r[0] <= in_tag;
      for (int l = 0; l < 3; l++) begin
        ovf_r[0][l] <= in_num[l][NUM_W-1:Q_W] >= {{(HI_W-ROOT_W){1'b0}}, in_len};
        rem_r[0][l] <= in_num[l][Q_W+ROOT_W-1:Q_W];
        low_r[0][l] <= in_num[l][Q_W-1:0];
      end
    end
  end

  // Quotient bit stages
  for (genvar s = 1; s < NS; s++) begin : g_st
    logic [ROOT_W:0] t    [3];
    logic [ROOT_W:0] diff [3];
    logic [2:0]      take;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        t[l]    = {rem_r[s-1][l], low_r[s-1][l][Q_W-1]};
        take[l] = t[l] >= {1'b0, len_r[s-1]};
        diff[l] = t[l] - {1'b0, len_r[s-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[s] <= len_r[s-1];
        tag_r[s] <= tag_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        for (int l = 0; l < 3; l++) begin
          rem_r[s][l] <= take[l] ? diff[l][ROOT_W-1:0] : t[l][ROOT_W-1:0];
          low_r[s][l] <= {low_r[s-1][l][Q_W-2:0], take[l]};
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_tag   = tag_r[NS-1];
  always_comb begin
    for (int l = 0; l < 3; l++) out_q[l] = low_r[NS-1][l];
  end

endmodule
